@@ src/pke_pkg.sv @@
// Package with the types, constants and helper functions of the protein k-mer extractor.
`default_nettype none

package pke_pkg;

    localparam int K_MAX_DEF      = 4;
    localparam int STAMP_BITS_DEF = 16;

    localparam int CODE_W     = 5;
    localparam int ALPHA_SIZE = 20;
    localparam logic [CODE_W-1:0] BAD_CODE = 5'd31;

    localparam int KLEN_W  = 3;
    localparam int RANGE_W = 18;
    localparam int SEQ_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [KLEN_W-1:0]  KMER_LENGTH_RST = 3'd3;
    localparam logic [RANGE_W-1:0] RANGE_LOW_RST   = 18'd0;
    localparam logic [RANGE_W-1:0] RANGE_HIGH_RST  = 18'd160000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KMER_LENGTH = 2'd0,
        CFG_UNIQUE_ONLY = 2'd1,
        CFG_RANGE_LOW   = 2'd2,
        CFG_RANGE_HIGH  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] residue;
        logic       seq_end;
    } item_t;

    typedef struct packed {
        logic [RANGE_W-1:0] kmer_offset;
        logic [SEQ_W-1:0]   seq_number;
    } kmer_t;

    typedef struct packed {
        logic [KLEN_W-1:0]  kmer_length;
        logic               unique_only;
        logic [RANGE_W-1:0] range_low;
        logic [RANGE_W-1:0] range_high;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CALC,
        ST_LOOKUP,
        ST_DECIDE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clear;
        logic calc;
        logic lookup;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wrap;
        logic clear_done;
        logic emit;
        logic out_free;
    } status_t;

    // Number of entries of the stamp table: 20 to the power n.
    function automatic int pow20(input int n);
        int acc;
        acc = 1;
        for (int i = 0; i < n; i++) begin
            acc = acc * ALPHA_SIZE;
        end
        return acc;
    endfunction

    // Position of a letter in the amino-acid alphabet, or the bad code.
    function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            "A":     code = 5'd0;
            "C":     code = 5'd1;
            "D":     code = 5'd2;
            "E":     code = 5'd3;
            "F":     code = 5'd4;
            "G":     code = 5'd5;
            "H":     code = 5'd6;
            "I":     code = 5'd7;
            "K":     code = 5'd8;
            "L":     code = 5'd9;
            "M":     code = 5'd10;
            "N":     code = 5'd11;
            "P":     code = 5'd12;
            "Q":     code = 5'd13;
            "R":     code = 5'd14;
            "S":     code = 5'd15;
            "T":     code = 5'd16;
            "V":     code = 5'd17;
            "W":     code = 5'd18;
            "Y":     code = 5'd19;
            default: code = BAD_CODE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ src/pke_cfg_regs.sv @@
// Configuration register bank of the protein k-mer extractor.
`default_nettype none

module pke_cfg_regs
    import pke_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KMER_LENGTH: cfg_next.kmer_length = cfg_data[KLEN_W-1:0];
                CFG_UNIQUE_ONLY: cfg_next.unique_only = cfg_data[0];
                CFG_RANGE_LOW:   cfg_next.range_low   = cfg_data[RANGE_W-1:0];
                CFG_RANGE_HIGH:  cfg_next.range_high  = cfg_data[RANGE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kmer_length <= KMER_LENGTH_RST;
            cfg_reg.unique_only <= 1'b0;
            cfg_reg.range_low   <= RANGE_LOW_RST;
            cfg_reg.range_high  <= RANGE_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/pke_ctrl.sv @@
// Controller state machine that sequences one residue at a time through the datapath.
`default_nettype none

module pke_ctrl
    import pke_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire status_t status,
    output logic         item_stall,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = status.wrap ? ST_CLEAR : ST_CALC;
                end
            end
            ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:   state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (!status.emit || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall = (state_reg != ST_IDLE);
        cmd        = '0;
        case (state_reg)
            ST_IDLE:   cmd.accept = item_valid;
            ST_CLEAR:  cmd.clear  = 1'b1;
            ST_CALC:   cmd.calc   = 1'b1;
            ST_LOOKUP: cmd.lookup = 1'b1;
            ST_DECIDE: cmd.load   = status.emit && status.out_free;
            default:   cmd        = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ src/pke_dpath.sv @@
// Datapath: residue window, k-mer index, stamp table and output register.
`default_nettype none

module pke_dpath
    import pke_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire item_t item,
    input  wire cmd_t  cmd,
    output status_t    status,
    output logic       kmer_valid,
    input  wire logic  kmer_stall,
    output kmer_t      kmer
);

    localparam int SEEN_DEPTH = pow20(K_MAX);
    localparam int IDX_W      = $clog2(SEEN_DEPTH);
    localparam int CMP_W      = (IDX_W > RANGE_W) ? IDX_W : RANGE_W;
    localparam int FILL_W     = $clog2(K_MAX + 1);
    localparam logic [IDX_W-1:0]      LAST_ADDR = IDX_W'(SEEN_DEPTH - 1);
    localparam logic [STAMP_BITS-1:0] GEN_ONES  = {STAMP_BITS{1'b1}};
    localparam logic [STAMP_BITS-1:0] GEN_FIRST = STAMP_BITS'(1);

    logic [CODE_W-1:0]     win_reg [K_MAX];
    logic [CODE_W-1:0]     win_next [K_MAX];
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic                  in_seq_reg;
    logic [STAMP_BITS-1:0] gen_reg, gen_next;
    logic [SEQ_W-1:0]      seq_cnt_reg;
    logic [SEQ_W-1:0]      item_seq_reg;

    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  win_ok_reg, win_ok_next;
    logic                  hit_reg;
    logic [STAMP_BITS-1:0] rdata_reg;
    logic [IDX_W-1:0]      clr_addr_reg;

    logic                  out_valid_reg;
    kmer_t                 out_reg;

    logic [STAMP_BITS-1:0] stamp_mem [SEEN_DEPTH];
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [STAMP_BITS-1:0] mem_wdata;

    logic [KLEN_W-1:0]     k_eff;
    logic                  seq_start;
    logic [CMP_W-1:0]      idx_cmp;

    assign seq_start = !in_seq_reg;

    // Out-of-range lengths are clamped to one and K_MAX.
    always_comb
    begin
        if (cfg.kmer_length == '0)
        begin
            k_eff = KLEN_W'(1);
        end
        else if (int'(cfg.kmer_length) > K_MAX)
        begin
            k_eff = KLEN_W'(K_MAX);
        end
        else
        begin
            k_eff = cfg.kmer_length;
        end
    end

    // Window shift on an accepted residue; entry 0 is the newest.
    always_comb
    begin
        win_next[0] = letter_code(item.residue);
        for (int i = 1; i < K_MAX; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
        fill_next = seq_start ? '0 : fill_reg;
        if (int'(fill_next) < K_MAX)
        begin
            fill_next = fill_next + FILL_W'(1);
        end
        gen_next = gen_reg;
        if (seq_start && cfg.unique_only)
        begin
            gen_next = (gen_reg == GEN_ONES) ? GEN_FIRST : gen_reg + GEN_FIRST;
        end
    end

    // Base-20 index, oldest residue first, over the first k entries.
    always_comb
    begin
        idx_next    = '0;
        win_ok_next = (KLEN_W'(fill_reg) >= k_eff);
        for (int i = K_MAX - 1; i >= 0; i--)
        begin
            if (i < int'(k_eff))
            begin
                idx_next = IDX_W'(idx_next * ALPHA_SIZE) + IDX_W'(win_reg[i]);
                if (win_reg[i] == BAD_CODE)
                begin
                    win_ok_next = 1'b0;
                end
            end
        end
    end

    assign idx_cmp = CMP_W'(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < K_MAX; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg    <= '0;
            in_seq_reg  <= 1'b0;
            gen_reg     <= GEN_ONES;
            seq_cnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            in_seq_reg  <= !item.seq_end;
            gen_reg     <= gen_next;
            seq_cnt_reg <= seq_cnt_reg + SEQ_W'(item.seq_end);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_seq_reg <= seq_cnt_reg;
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
        end
        if (cmd.calc)
        begin
            idx_reg    <= idx_next;
            win_ok_reg <= win_ok_next;
        end
        if (cmd.lookup)
        begin
            hit_reg <= win_ok_reg && (idx_cmp >= CMP_W'(cfg.range_low))
                       && (idx_cmp < CMP_W'(cfg.range_high));
        end
    end

    // Stamp table: one write port shared by the clearing sweep and the stamp update.
    always_comb
    begin
        mem_we    = cmd.clear || (cmd.load && cfg.unique_only);
        mem_waddr = cmd.clear ? clr_addr_reg : idx_reg;
        mem_wdata = cmd.clear ? '0 : gen_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stamp_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            rdata_reg <= stamp_mem[idx_reg];
        end
    end

    always_comb
    begin
        status.wrap       = seq_start && cfg.unique_only && (gen_reg == GEN_ONES);
        status.clear_done = (clr_addr_reg == LAST_ADDR);
        status.emit       = hit_reg && (!cfg.unique_only || (rdata_reg != gen_reg));
        status.out_free   = !out_valid_reg || !kmer_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!kmer_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_reg.kmer_offset <= RANGE_W'(idx_cmp - CMP_W'(cfg.range_low));
            out_reg.seq_number  <= item_seq_reg;
        end
    end

    assign kmer_valid = out_valid_reg;
    assign kmer       = out_reg;

endmodule

`default_nettype wire

@@ src/protein_kmer_extractor_top.sv @@
// Top level of the protein k-mer extractor: configuration bank, controller and datapath.
`default_nettype none

// The block takes one ASCII amino-acid residue per transfer on the item channel, with
// seq_end marking the last residue of a sequence, and returns at most one transfer on
// the kmer channel per residue: the base-20 index of the last kmer_length residues
// (oldest first, alphabet ACDEFGHIKLMNPQRSTVWY) minus range_low, together with the
// number of sequences completed before the current one. Windows that hold a letter
// outside the alphabet, windows not yet full, and indices outside
// [range_low, range_high) give nothing. With unique_only set, a stamp table of
// 20^K_MAX entries drops repeats of an index within a sequence. Each residue passes
// through four steps before the next residue can be taken: capture and window shift,
// index computation, stamp table read, then the decision and output load; the last
// step waits while a previous result is still held on the kmer channel. The stamp
// table has one read and one write port and is not cleared by reset: when the
// generation stamp wraps, which also happens at the first sequence processed in
// unique mode after reset, the block sweeps the whole table, one entry per cycle,
// before it finishes that residue, and takes no residue meanwhile. Configuration
// writes are accepted in every cycle and belong only to times when no residue is in
// flight.

module protein_kmer_extractor_top
    import pke_pkg::*;
#(
    parameter int K_MAX      = K_MAX_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       kmer_valid,
    input  wire logic                  kmer_stall,
    output kmer_t                      kmer,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Register writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;

    pke_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The controller admits a residue only from its idle state and then walks it
    // through the datapath steps.
    pke_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // The datapath owns the window, the stamp table and the output register, so a
    // finished result can wait on the kmer channel while the next residue is taken.
    pke_dpath #(
        .K_MAX      (K_MAX),
        .STAMP_BITS (STAMP_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .cmd        (cmd),
        .status     (status),
        .kmer_valid (kmer_valid),
        .kmer_stall (kmer_stall),
        .kmer       (kmer)
    );

endmodule

`default_nettype wire

@@ src/pke_checker.sv @@
// Port-level checker of the protein k-mer extractor and its bind to the top level.
`default_nettype none

module pke_checker
    import pke_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  item_valid,
    input wire logic  item_stall,
    input wire logic  kmer_valid,
    input wire logic  kmer_stall,
    input wire kmer_t kmer
);

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        kmer_valid && kmer_stall |=> kmer_valid)
        else $error("kmer result dropped while stalled");

    // A held result does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        kmer_valid && kmer_stall |=> $stable(kmer))
        else $error("kmer payload changed while stalled");

    // Residues are handled one at a time: a transfer closes the item channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("residue taken while another is in flight");

    // A new result is loaded only while a residue is being processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(kmer_valid) |-> $past(item_stall))
        else $error("result appeared without a residue in flight");

endmodule

bind protein_kmer_extractor_top pke_checker u_pke_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the protein k-mer extractor top level.
`default_nettype none

// The bench drives ASCII residues into the item channel and predicts each k-mer
// transfer on the kmer channel. Its own copy of the sliding window, the sequence
// counter, the generation stamp and the stamp table runs beside the block. Every
// accepted result is checked field by field against the oldest waiting expectation.
//
// The run has two parts. A short table of directed residues runs under the reset
// register values. It covers the corner letters, a bad byte at each end of the byte
// range, a sequence shorter than the window, and every letter of the alphabet. A few
// rows carry results that can be worked out by hand, others must give nothing, and
// the rest are checked against the predictor.
//
// Random phases follow, each under its own register setting. The settings cover
// every window length from 0 to 7, unique mode on and off, and ranges that are full,
// narrow, empty and beyond the table size. Registers are only written once the block
// is idle and every sequence is closed. That way unique mode never starts in the
// middle of a sequence.
//
// The first sequence in unique mode makes the generation stamp wrap. The block then
// sweeps its whole stamp table and takes no residue meanwhile. The watchdog limit is
// sized for that.

module testbench;
    import pke_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A quiet stretch with no transfer on any channel that reaches this limit ends the
    // run. The longest legal quiet stretch is the stamp table sweep.
    localparam int WATCHDOG_LIMIT = 500000;

    // The alphabet, one byte per letter, with the letter of code 0 in the top byte.
    localparam logic [8*ALPHA_SIZE-1:0] AMINO = "ACDEFGHIKLMNPQRSTVWY";

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    item_t      item = '0;
    logic       kmer_valid;
    logic       kmer_stall = 1'b0;
    kmer_t      kmer;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_KMER_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    protein_kmer_extractor_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .kmer_valid (kmer_valid),
        .kmer_stall (kmer_stall),
        .kmer       (kmer),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // The predictor's copy of the registers and of the block's state.
    cfg_t            reg_shadow = '{kmer_length: KMER_LENGTH_RST, unique_only: 1'b0,
                                    range_low: RANGE_LOW_RST, range_high: RANGE_HIGH_RST};
    logic [CODE_W-1:0] window [K_MAX_DEF];
    int unsigned     window_fill = 0;
    bit              in_sequence = 1'b0;
    logic [15:0]     generation = 16'hFFFF;
    logic [15:0]     seen_stamp [int unsigned];
    logic [SEQ_W-1:0] sequence_count = '0;

    kmer_t pending_kmers [$];
    int    mismatch_count = 0;
    int    quiet_cycles = 0;
    int    burst_left = 0;

    // Directed residues. Known rows hold a result that is plain from the window
    // contents, silent rows must produce no transfer, and the others go to the
    // predictor. All of them run with a window of three and the full range.
    typedef enum {ROW_PREDICT, ROW_SILENT, ROW_KNOWN} row_check_t;

    typedef struct {
        logic [7:0]  residue;
        logic        seq_end;
        row_check_t  check;
        int unsigned offset;
        int unsigned seq;
    } probe_row_t;

    probe_row_t probes [26] = '{
        // Sequence 0: the first two residues only fill the window.
        '{"A",   1'b0, ROW_SILENT,  0,    0},
        '{"A",   1'b0, ROW_SILENT,  0,    0},
        '{"A",   1'b0, ROW_KNOWN,   0,    0},
        '{"Y",   1'b0, ROW_KNOWN,   19,   0},
        '{"Y",   1'b0, ROW_KNOWN,   399,  0},
        '{"Y",   1'b1, ROW_KNOWN,   7999, 0},
        // Sequence 1: the window restarts, and a zero byte blocks three windows.
        '{"C",   1'b0, ROW_SILENT,  0,    0},
        '{"D",   1'b0, ROW_SILENT,  0,    0},
        '{"E",   1'b0, ROW_KNOWN,   443,  1},
        '{"F",   1'b0, ROW_PREDICT, 0,    0},
        '{"G",   1'b0, ROW_PREDICT, 0,    0},
        '{"H",   1'b0, ROW_PREDICT, 0,    0},
        '{8'h00, 1'b0, ROW_SILENT,  0,    0},
        '{"I",   1'b0, ROW_SILENT,  0,    0},
        '{"K",   1'b0, ROW_SILENT,  0,    0},
        '{"L",   1'b1, ROW_PREDICT, 0,    0},
        // Sequence 2: a single residue, shorter than the window.
        '{"W",   1'b1, ROW_SILENT,  0,    0},
        // Sequence 3: the rest of the alphabet, closed by an all-ones byte.
        '{"M",   1'b0, ROW_SILENT,  0,    0},
        '{"N",   1'b0, ROW_SILENT,  0,    0},
        '{"P",   1'b0, ROW_PREDICT, 0,    0},
        '{"Q",   1'b0, ROW_PREDICT, 0,    0},
        '{"R",   1'b0, ROW_PREDICT, 0,    0},
        '{"S",   1'b0, ROW_PREDICT, 0,    0},
        '{"T",   1'b0, ROW_PREDICT, 0,    0},
        '{"V",   1'b0, ROW_PREDICT, 0,    0},
        '{8'hFF, 1'b1, ROW_SILENT,  0,    0}
    };

    function automatic logic [7:0] amino_letter(input int unsigned code);
        return AMINO[8*(ALPHA_SIZE-1-code) +: 8];
    endfunction

    // Advances the predicted state by one residue. It returns 1 when the residue
    // should give a k-mer transfer and leaves that transfer in res.
    function automatic bit predict_kmer(input item_t it, output kmer_t res);
        int unsigned k;
        int unsigned idx;
        int unsigned bad;
        logic [CODE_W-1:0] code;
        logic [15:0] stamp;
        bit hit;
        hit = 1'b0;
        res = '0;
        idx = 0;
        bad = 0;
        // A length of zero acts as one, and anything past the window depth acts as
        // the full depth.
        if (reg_shadow.kmer_length == 0)
            k = 1;
        else if (reg_shadow.kmer_length > K_MAX_DEF)
            k = K_MAX_DEF;
        else
            k = reg_shadow.kmer_length;

        // The first residue of a sequence empties the window. In unique mode it also
        // opens a new generation, and a wrap of the stamp wipes the table.
        if (!in_sequence) begin
            window_fill = 0;
            if (reg_shadow.unique_only) begin
                generation = generation + 16'd1;
                if (generation == 16'd0) begin
                    seen_stamp.delete();
                    generation = 16'd1;
                end
            end
        end

        code = BAD_CODE;
        for (int i = 0; i < ALPHA_SIZE; i++) begin
            if (amino_letter(i) == it.residue)
                code = CODE_W'(i);
        end
        for (int i = K_MAX_DEF - 1; i > 0; i--) begin
            window[i] = window[i-1];
        end
        window[0] = code;
        if (window_fill < K_MAX_DEF)
            window_fill++;

        for (int i = 0; i < k && i < window_fill; i++) begin
            if (window[i] >= ALPHA_SIZE)
                bad++;
        end

        if (window_fill >= k && bad == 0) begin
            // The oldest residue in the window is the most significant digit.
            for (int i = k - 1; i >= 0; i--) begin
                idx = idx * ALPHA_SIZE + window[i];
            end
            if (idx >= reg_shadow.range_low && idx < reg_shadow.range_high) begin
                hit = 1'b1;
                if (reg_shadow.unique_only) begin
                    stamp = seen_stamp.exists(idx) ? seen_stamp[idx] : 16'd0;
                    if (stamp == generation)
                        hit = 1'b0;
                    else
                        seen_stamp[idx] = generation;
                end
                if (hit) begin
                    res.kmer_offset = RANGE_W'(idx - reg_shadow.range_low);
                    res.seq_number  = sequence_count;
                end
            end
        end

        if (it.seq_end) begin
            sequence_count = sequence_count + 1'b1;
            in_sequence = 1'b0;
        end else begin
            in_sequence = 1'b1;
        end
        return hit;
    endfunction

    // Presents one residue and holds it until the block takes the transfer. The
    // prediction is made in the same step as the transfer.
    task automatic send_residue(input item_t it, output bit hit, output kmer_t res);
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        hit = predict_kmer(it, res);
    endtask

    // Spacing between residues. Most gaps are short, a few are long, and now and then
    // a burst goes through with valid held high throughout.
    task automatic pace_sender();
        int pick;
        int gap;
        if (burst_left != 0) begin
            burst_left--;
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            burst_left = $urandom_range(30, 80);
            gap = 0;
        end else if (pick < 60) begin
            gap = 0;
        end else if (pick < 88) begin
            gap = $urandom_range(1, 3);
        end else if (pick < 97) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap != 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The sender stops until every predicted transfer has arrived. The loop waits on the
    // clock before it checks, so valid is never lowered and raised in the same step.
    task automatic drain_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_kmers.size() != 0);
    endtask

    // Writes one register. Valid stays high so that back-to-back writes need no
    // second assignment in a step. The caller lowers it after the last write.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_KMER_LENGTH: reg_shadow.kmer_length = data[KLEN_W-1:0];
            CFG_UNIQUE_ONLY: reg_shadow.unique_only = data[0];
            CFG_RANGE_LOW:   reg_shadow.range_low   = data[RANGE_W-1:0];
            CFG_RANGE_HIGH:  reg_shadow.range_high  = data[RANGE_W-1:0];
            default: ;
        endcase
    endtask

    // One random phase. The registers are written while the block is idle, and then
    // whole sequences run. Each sequence either draws from the full alphabet or from a
    // pair of neighboring letters, which makes repeats common for unique mode. A few
    // stray bytes break windows.
    task automatic run_phase(input logic [KLEN_W-1:0] klen, input logic uniq,
                             input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi,
                             input int items);
        int    left;
        int    len;
        int    narrow;
        int    base;
        item_t it;
        bit    hit;
        kmer_t res;
        write_reg(CFG_KMER_LENGTH, CFG_DATA_W'(klen));
        write_reg(CFG_UNIQUE_ONLY, CFG_DATA_W'(uniq));
        write_reg(CFG_RANGE_LOW, CFG_DATA_W'(lo));
        write_reg(CFG_RANGE_HIGH, CFG_DATA_W'(hi));
        cfg_valid <= 1'b0;

        left = items;
        while (left > 0) begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 50);
            if (len > left)
                len = left;
            narrow = ($urandom_range(0, 2) != 0);
            base = $urandom_range(0, ALPHA_SIZE - 2);
            for (int p = 0; p < len; p++) begin
                if ($urandom_range(0, 99) < 8)
                    it.residue = 8'($urandom_range(0, 255));
                else if (narrow)
                    it.residue = amino_letter(base + $urandom_range(0, 1));
                else
                    it.residue = amino_letter($urandom_range(0, ALPHA_SIZE - 1));
                it.seq_end = (p == len - 1);
                send_residue(it, hit, res);
                if (hit)
                    pending_kmers.push_back(res);
                pace_sender();
            end
            left -= len;
            // Once in a while the sender waits for the block to empty completely.
            if ($urandom_range(0, 99) < 3)
                drain_results();
        end
        // The last residue may give no result and still be in flight, so the sender waits
        // out that residue's steps before the next register write.
        drain_results();
        repeat (10) @(posedge clk);
    endtask

    // The result side stalls in short bursts, sometimes in long ones, and has quiet
    // stretches with no stall at all.
    int unsigned hold_left = 0;
    int unsigned open_left = 0;

    always @(posedge clk) begin : stall_gen
        int pick;
        if (open_left != 0) begin
            open_left <= open_left - 1;
            kmer_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            kmer_stall <= 1'b1;
        end else begin
            kmer_stall <= 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                open_left <= $urandom_range(50, 300);
            else if (pick < 6)
                hold_left <= $urandom_range(10, 40);
            else if (pick < 35)
                hold_left <= $urandom_range(1, 3);
        end
    end

    // Every k-mer transfer is compared field by field with the oldest expectation.
    always @(posedge clk) begin : kmer_check
        kmer_t want;
        if (rst_n && kmer_valid && !kmer_stall) begin
            if (pending_kmers.size() == 0) begin
                $error("unexpected k-mer transfer: kmer_offset %0d, seq_number %0d",
                       kmer.kmer_offset, kmer.seq_number);
                mismatch_count++;
            end else begin
                want = pending_kmers.pop_front();
                if (kmer.kmer_offset !== want.kmer_offset) begin
                    $error("kmer_offset mismatch: expected %0d, actual %0d",
                           want.kmer_offset, kmer.kmer_offset);
                    mismatch_count++;
                end
                if (kmer.seq_number !== want.seq_number) begin
                    $error("seq_number mismatch: expected %0d, actual %0d",
                           want.seq_number, kmer.seq_number);
                    mismatch_count++;
                end
            end
        end
    end

    // The watchdog counts cycles with no transfer on any channel.
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (kmer_valid && !kmer_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        item_t it;
        bit    hit;
        kmer_t res;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset register values.
        foreach (probes[r]) begin
            it.residue = probes[r].residue;
            it.seq_end = probes[r].seq_end;
            send_residue(it, hit, res);
            case (probes[r].check)
                ROW_KNOWN: begin
                    res.kmer_offset = RANGE_W'(probes[r].offset);
                    res.seq_number  = SEQ_W'(probes[r].seq);
                    pending_kmers.push_back(res);
                end
                ROW_SILENT: ;
                default: begin
                    if (hit)
                        pending_kmers.push_back(res);
                end
            endcase
            pace_sender();
        end
        drain_results();
        repeat (10) @(posedge clk);

        // Random phases. The first unique phase triggers the full stamp table sweep.
        run_phase(3'd1, 1'b0, 18'd0,      18'd160000, 150);
        run_phase(3'd2, 1'b1, 18'd0,      18'h3FFFF,  200);
        run_phase(3'd4, 1'b1, 18'd0,      18'd160000, 200);
        run_phase(3'd0, 1'b1, 18'd3,      18'd17,     150);
        run_phase(3'd2, 1'b0, 18'd50,     18'd250,    150);
        run_phase(3'd7, 1'b0, 18'd80000,  18'd160000, 150);
        run_phase(3'd5, 1'b1, 18'd1000,   18'h3FFFF,  150);
        // Empty ranges, one with equal bounds and one with the bounds reversed.
        run_phase(3'd3, 1'b0, 18'd300,    18'd300,    100);
        run_phase(3'd6, 1'b1, 18'h3FFFF,  18'd0,      100);
        run_phase(3'd3, 1'b0, 18'd0,      18'd160000, 175);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_kmers.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
